[rtl/pts_pkg.sv]
// pts_pkg: shared types, widths and constants of the poll timing stabilizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pts_pkg;

    localparam int DATA_W   = 64;          // wrap width of all timing arithmetic
    localparam int TS_W     = 62;          // timestamp width
    localparam int NEXT_W   = 63;          // predicted timing width
    localparam int CNT_W    = 9;           // stamp count / history limit width
    localparam int PER_W    = 36;          // period, Q28.8 ns
    localparam int NS_W     = 30;          // leniency and delay width
    localparam int STEP_W   = 32;          // period step counter width
    localparam int FRAC_W   = 8;           // period fraction bits

    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = PER_W;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    localparam int DIV_STEPS = DATA_W;     // one quotient bit per cycle

    localparam int MAX_HISTORY = 256;      // ceiling on the effective history limit
    localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(MAX_HISTORY);

    localparam int CFG_DATA_W = PER_W;
    localparam int CFG_ADDR_W = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LENIENCY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT    = 2'd3;

    // reset values
    localparam logic [PER_W-1:0] PERIOD_RST   = 36'd4270937604;  // 1e9/59.94 in Q8
    localparam logic [NS_W-1:0]  LENIENCY_RST = 30'd1400000;
    localparam logic [NS_W-1:0]  DELAY_RST    = 30'd1400000;
    localparam logic [CNT_W-1:0] LIMIT_RST    = 9'd32;

    // operation codes carried in tuser
    localparam logic OP_FEED  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_F_BAND,
        S_F_ACC,
        S_F_UPDATE,
        S_SF_DIFF,
        S_SF_CMP,
        S_SQ_OFF,
        S_SQ_SUM,
        S_MEAN_TRI,
        S_MEAN_ACT,
        S_MEAN_NUM,
        S_MEAN_ABS,
        S_MEAN_DIV,
        S_MEAN_SUM,
        S_Q_DLY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/pts_mul.sv]
// pts_mul: shared 32x36 unsigned multiplier with a registered product.
// Depends on pts_pkg for operand widths.
`timescale 1ns / 1ps

module pts_mul import pts_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [MUL_P_W-1:0] r_prod;

    // product is registered and ready in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[rtl/pts_div.sv]
// pts_div: restoring divider, 64-bit dividend by a 9-bit count, one bit a cycle.
// Depends on pts_pkg for widths and the status struct.
`timescale 1ns / 1ps

module pts_div import pts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic [DATA_W-1:0] o_quot,
    output t_div_stat         o_stat
);

    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    logic [DATA_W-1:0]     r_q;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_div;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [CNT_W:0]        trial;
    logic                  qbit;
    logic [CNT_W:0]        diff;

    // remainder stays below the divisor, so it never needs more than CNT_W bits
    assign trial = {r_rem, r_q[DATA_W-1]};
    assign qbit  = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DATA_W-2:0], qbit};
            r_rem <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[rtl/poll_timing_stabilizer.sv]
// Poll timing stabilizer: each accepted beat steps through the state machine to a registered
// result; a beat that forms the running mean (non-empty query below the limit, or the feed
// that fills the history) also waits out the full pass of the 64-step shared divider.
// One beat in flight; the block returns to idle and takes the next beat once the result is
// registered, while the result waits in the output register.
// Reset (i_rst_n low, synchronous) clears history, origin, steps; loads default config.
`timescale 1ns / 1ps

module poll_timing_stabilizer import pts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // [61:0] timestamp_ns, [62] advance, [63] zero
    input  logic                  s_axis_tuser,  // [0] op (0 feed, 1 query)
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,  // [62:0] next_timing_ns, [71:63] history_count
    output logic [1:0]            m_axis_tuser   // [0] steady, [1] restarted
);

    // ---------------------------------------------------------------- config
    logic [PER_W-1:0] r_period;
    logic [NS_W-1:0]  r_len;
    logic [NS_W-1:0]  r_delay;
    logic [CNT_W-1:0] r_hist_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= PERIOD_RST;
            r_len        <= LENIENCY_RST;
            r_delay      <= DELAY_RST;
            r_hist_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PERIOD:   r_period     <= i_cfg_data[PER_W-1:0];
                CFG_LENIENCY: r_len        <= i_cfg_data[NS_W-1:0];
                CFG_DELAY:    r_delay      <= i_cfg_data[NS_W-1:0];
                CFG_LIMIT:    r_hist_limit <= i_cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // limit 0 acts as 1, anything above the ceiling is clamped
    logic [CNT_W-1:0] eff_limit;
    always_comb begin
        if (r_hist_limit == '0) begin
            eff_limit = CNT_W'(1);
        end else if (r_hist_limit > LIMIT_MAX) begin
            eff_limit = LIMIT_MAX;
        end else begin
            eff_limit = r_hist_limit;
        end
    end

    // ---------------------------------------------------------------- state
    t_state            r_state, n_state;

    // architectural history
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [TS_W-1:0]   r_latest, n_latest;
    logic [DATA_W-1:0] r_offset, n_offset;
    logic [DATA_W-1:0] r_origin, n_origin;
    logic [STEP_W-1:0] r_steps,  n_steps;

    // beat in flight and scratch
    logic              r_op,  n_op;
    logic [TS_W-1:0]   r_tp,  n_tp;
    logic              r_adv, n_adv;
    logic [DATA_W-1:0] r_acc, n_acc;      // working accumulator, holds the answer at the end
    logic              r_neg, n_neg;      // sign carried around a magnitude operation
    logic              r_fix, n_fix;      // +1 correction for truncation toward zero
    logic              r_restart, n_restart;

    // result register
    logic              r_out_valid, n_out_valid;
    logic [71:0]       r_out_data,  n_out_data;
    logic [1:0]        r_out_user,  n_out_user;

    // shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic               div_start;
    logic [DATA_W-1:0]  div_dividend;
    logic [DATA_W-1:0]  div_quot;
    t_div_stat          div_stat;

    pts_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    // ---------------------------------------------------------------- shared terms
    logic                accept;
    logic                is_steady;
    logic [CNT_W-1:0]    cnt_inc;
    logic [DATA_W-1:0]   tp64, latest64;
    logic [DATA_W-1:0]   whole;          // product truncated to whole ns
    logic                frac_nz;
    logic                out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign is_steady     = (r_count >= eff_limit);
    assign cnt_inc       = r_count + 1'b1;   // only used below the limit, no overflow
    assign tp64          = {{(DATA_W-TS_W){1'b0}}, r_tp};
    assign latest64      = {{(DATA_W-TS_W){1'b0}}, r_latest};
    assign whole         = DATA_W'(prod[MUL_P_W-1:FRAC_W]);
    assign frac_nz       = |prod[FRAC_W-1:0];
    assign out_free      = ~r_out_valid | m_axis_tready;

    // gap band check on r_acc = tp - latest (signed)
    localparam logic signed [DATA_W-1:0] GAP_LIM = 64'sd4294967296;
    localparam int BAND_W = 44;

    logic                      gap_big;
    logic signed [BAND_W-1:0]  g8, band_hi, band_lo;
    logic                      out_band;
    logic [DATA_W-1:0]         acc_neg;
    logic [32:0]               gap_abs;
    logic [DATA_W-1:0]         acc_mag;

    assign gap_big  = ($signed(r_acc) > GAP_LIM) || ($signed(r_acc) < -GAP_LIM);
    assign g8       = $signed({r_acc[BAND_W-FRAC_W-1:0], {FRAC_W{1'b0}}});
    assign band_hi  = $signed(BAND_W'(r_period)) + $signed(BAND_W'({r_len, {FRAC_W{1'b0}}}));
    assign band_lo  = $signed(BAND_W'(r_period)) - $signed(BAND_W'({r_len, {FRAC_W{1'b0}}}));
    assign out_band = gap_big || (g8 > band_hi) || (g8 < band_lo);
    assign acc_neg  = -r_acc;
    assign gap_abs  = r_acc[DATA_W-1] ? acc_neg[32:0] : r_acc[32:0];
    assign acc_mag  = r_acc[DATA_W-1] ? acc_neg : r_acc;

    // steady offset: whole - delay, borrow tells whether the true value is negative
    logic [DATA_W:0] sq_diff;
    assign sq_diff = {1'b0, whole} - {{(DATA_W+1-NS_W){1'b0}}, r_delay};

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (r_op == OP_FEED) begin
                    if (is_steady)             n_state = S_SF_DIFF;
                    else if (r_count != '0)    n_state = S_F_BAND;
                    else                       n_state = S_F_UPDATE;
                end else begin
                    if (r_count == '0)         n_state = S_DONE;
                    else if (is_steady)        n_state = S_SQ_OFF;
                    else                       n_state = S_MEAN_TRI;
                end
            end
            S_F_BAND:   n_state = out_band ? S_F_UPDATE : S_F_ACC;
            S_F_ACC:    n_state = S_F_UPDATE;
            S_F_UPDATE: n_state = (cnt_inc == eff_limit) ? S_MEAN_TRI : S_DONE;
            S_SF_DIFF:  n_state = S_SF_CMP;
            S_SF_CMP:   n_state = S_DONE;
            S_SQ_OFF:   n_state = S_SQ_SUM;
            S_SQ_SUM:   n_state = S_DONE;
            S_MEAN_TRI: n_state = S_MEAN_ACT;
            S_MEAN_ACT: n_state = S_MEAN_NUM;
            S_MEAN_NUM: n_state = S_MEAN_ABS;
            S_MEAN_ABS: n_state = S_MEAN_DIV;
            S_MEAN_DIV: begin
                if (div_stat.done) n_state = S_MEAN_SUM;
            end
            S_MEAN_SUM: n_state = (r_op == OP_FEED) ? S_DONE : S_Q_DLY;
            S_Q_DLY:    n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        n_count      = r_count;
        n_latest     = r_latest;
        n_offset     = r_offset;
        n_origin     = r_origin;
        n_steps      = r_steps;
        n_op         = r_op;
        n_tp         = r_tp;
        n_adv        = r_adv;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_fix        = r_fix;
        n_restart    = r_restart;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_out_valid  = r_out_valid & ~m_axis_tready;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = acc_mag;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = s_axis_tuser;
                    n_tp      = s_axis_tdata[TS_W-1:0];
                    n_adv     = s_axis_tdata[TS_W];
                    n_restart = 1'b0;
                end
            end
            S_DISPATCH: begin
                if (r_op == OP_FEED) begin
                    if (is_steady) begin
                        n_acc = tp64 - r_origin;
                        mul_a = r_steps;
                        mul_b = r_period;
                    end else begin
                        n_acc = tp64 - latest64;    // signed gap
                    end
                end else begin
                    if (r_count == '0) begin
                        n_acc = tp64 - DATA_W'(r_delay);
                    end else if (is_steady) begin
                        mul_a = r_steps;
                        mul_b = r_period;
                    end
                end
            end
            S_F_BAND: begin
                if (out_band) begin
                    n_offset  = '0;
                    n_count   = '0;
                    n_restart = 1'b1;
                end else begin
                    // offset -= count * gap, done as a magnitude product
                    mul_a = MUL_A_W'(r_count);
                    mul_b = MUL_B_W'(gap_abs);
                    n_neg = r_acc[DATA_W-1];
                end
            end
            S_F_ACC: begin
                n_offset = r_neg ? r_offset + prod[DATA_W-1:0]
                                 : r_offset - prod[DATA_W-1:0];
            end
            S_F_UPDATE: begin
                n_latest = r_tp;
                n_count  = cnt_inc;
                if (cnt_inc == eff_limit) n_steps = '0;
            end
            S_SF_DIFF: begin
                n_acc = r_acc - whole;
            end
            S_SF_CMP: begin
                // stray from the steady trend restarts history at this stamp
                if (acc_mag > DATA_W'(r_len)) begin
                    n_offset  = '0;
                    n_count   = CNT_W'(1);
                    n_latest  = r_tp;
                    n_restart = 1'b1;
                end
            end
            S_SQ_OFF: begin
                n_acc = sq_diff[DATA_W-1:0];
                n_fix = sq_diff[DATA_W] & frac_nz;
            end
            S_SQ_SUM: begin
                n_acc = r_origin + r_acc + DATA_W'(r_fix);
                if (r_adv) n_steps = r_steps + 1'b1;
            end
            S_MEAN_TRI: begin
                mul_a = MUL_A_W'(r_count);
                mul_b = MUL_B_W'(r_count - 1'b1);
            end
            S_MEAN_ACT: begin
                // n(n-1)/2 fits 17 bits for any 9-bit count
                mul_a = MUL_A_W'(prod[17:1]);
                mul_b = r_period;
            end
            S_MEAN_NUM: begin
                n_acc = r_offset + whole;
            end
            S_MEAN_ABS: begin
                n_neg     = r_acc[DATA_W-1];
                div_start = 1'b1;
            end
            S_MEAN_DIV: begin
                if (div_stat.done) n_acc = r_neg ? -div_quot : div_quot;
            end
            S_MEAN_SUM: begin
                n_acc = latest64 + r_acc;
                if (r_op == OP_FEED) n_origin = latest64 + r_acc;
            end
            S_Q_DLY: begin
                n_acc = r_acc - DATA_W'(r_delay);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_count,
                                   (r_op == OP_QUERY) ? r_acc[NEXT_W-1:0] : {NEXT_W{1'b0}}};
                    n_out_user  = {r_restart, is_steady};
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_latest    <= '0;
            r_offset    <= '0;
            r_origin    <= '0;
            r_steps     <= '0;
            r_restart   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_latest    <= n_latest;
            r_offset    <= n_offset;
            r_origin    <= n_origin;
            r_steps     <= n_steps;
            r_restart   <= n_restart;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_tp       <= n_tp;
        r_adv      <= n_adv;
        r_acc      <= n_acc;
        r_neg      <= n_neg;
        r_fix      <= n_fix;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside completion");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LIMIT_MAX)
        else $error("stamp count beyond history ceiling");

    a_restart_on_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_restart |-> (r_op == OP_FEED))
        else $error("restart flagged on a query");
`endif

endmodule

[verif/pts_timing_checker.sv]
// pts_timing_checker: watches the config port and both streams of the poll timing
// stabilizer, predicts every result beat and compares it field by field.
// Depends on pts_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module pts_timing_checker import pts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // [61:0] timestamp_ns, [62] advance
    input  logic                  s_axis_tuser,  // [0] op
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [71:0]           m_axis_tdata,  // [62:0] next_timing_ns, [71:63] history_count
    input  logic [1:0]            m_axis_tuser,  // [0] steady, [1] restarted
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam longint GAP_SPAN = 64'sd4294967296;

    typedef struct packed {
        logic [NEXT_W-1:0] next_ns;
        logic              steady;
        logic [CNT_W-1:0]  count;
        logic              restarted;
    } t_timing_result;

    // shadow registers
    logic [PER_W-1:0]  period_q8;
    logic [NS_W-1:0]   leniency_ns;
    logic [NS_W-1:0]   delay_ns;
    logic [CNT_W-1:0]  limit_reg;

    // predictor state
    logic [CNT_W-1:0]  stamp_cnt;
    logic [DATA_W-1:0] last_stamp;
    logic [DATA_W-1:0] offset_acc;
    logic [DATA_W-1:0] origin;
    logic [STEP_W-1:0] steps;

    t_timing_result results_due[$];
    int fail_tally = 0;

    // k * period: whole ns, plus the 8 fraction bits that were dropped
    function automatic logic [63:0] scale_period(input logic [63:0] k,
                                                 output logic [7:0] frac);
        logic [63:0] a;
        logic [63:0] b;
        a = k * {60'd0, period_q8[35:32]};
        b = k * {32'd0, period_q8[31:0]};
        frac = b[7:0];
        return (a << 24) + (b >> 8);
    endfunction

    // latest stamp plus the mean offset, truncated toward zero, no delay
    function automatic logic [63:0] mean_timing();
        logic [63:0] n;
        logic [63:0] tri_n;
        logic [63:0] num;
        logic [63:0] mag;
        logic [63:0] q;
        logic [7:0]  frac;
        n = 64'(stamp_cnt);
        tri_n = (n * (n - 64'd1)) / 64'd2;
        num = offset_acc + scale_period(tri_n, frac);
        mag = num[63] ? -num : num;
        q = mag / n;
        return last_stamp + (num[63] ? -q : q);
    endfunction

    function automatic t_timing_result predict_beat(input logic op,
                                                    input logic [TS_W-1:0] ts,
                                                    input logic adv);
        t_timing_result r;
        logic [CNT_W-1:0] lim;
        logic [63:0] tp;
        logic [63:0] nxt;
        logic [63:0] whole;
        logic [63:0] dev;
        logic [63:0] mag;
        logic [63:0] gap_u;
        logic [7:0]  frac;
        longint      gap;
        longint      hi;
        longint      lo;
        logic        wild;

        if (limit_reg == '0)
            lim = CNT_W'(1);
        else if (limit_reg > LIMIT_MAX)
            lim = LIMIT_MAX;
        else
            lim = limit_reg;

        tp = 64'(ts);
        nxt = '0;
        r.restarted = 1'b0;

        if (op == OP_FEED) begin
            if (stamp_cnt >= lim) begin
                // steady: compare against the trend line
                whole = scale_period(64'(steps), frac);
                dev = tp - origin - whole;
                mag = dev[63] ? -dev : dev;
                if (mag > 64'(leniency_ns)) begin
                    offset_acc = '0;
                    stamp_cnt = CNT_W'(1);
                    last_stamp = tp;
                    r.restarted = 1'b1;
                end
            end else begin
                if (stamp_cnt != '0) begin
                    gap = longint'(tp - last_stamp);
                    hi = longint'({28'd0, period_q8}) + longint'({26'd0, leniency_ns, 8'd0});
                    lo = longint'({28'd0, period_q8}) - longint'({26'd0, leniency_ns, 8'd0});
                    if (gap > GAP_SPAN || gap < -GAP_SPAN)
                        wild = 1'b1;
                    else
                        wild = (gap * 256 > hi) || (gap * 256 < lo);
                    if (wild) begin
                        offset_acc = '0;
                        stamp_cnt = '0;
                        r.restarted = 1'b1;
                    end else begin
                        gap_u = gap;
                        offset_acc = offset_acc - 64'(stamp_cnt) * gap_u;
                    end
                end
                last_stamp = tp;
                stamp_cnt = stamp_cnt + CNT_W'(1);
                if (stamp_cnt == lim) begin
                    steps = '0;
                    origin = mean_timing();
                end
            end
        end else begin
            if (stamp_cnt == '0) begin
                nxt = tp - 64'(delay_ns);
            end else if (stamp_cnt >= lim) begin
                whole = scale_period(64'(steps), frac);
                nxt = whole - 64'(delay_ns);
                // round toward zero when the offset goes negative
                if (whole < 64'(delay_ns) && frac != 8'd0)
                    nxt = nxt + 64'd1;
                nxt = origin + nxt;
                if (adv)
                    steps = steps + STEP_W'(1);
            end else begin
                nxt = mean_timing() - 64'(delay_ns);
            end
        end

        r.next_ns = nxt[NEXT_W-1:0];
        r.steady = (stamp_cnt >= lim);
        r.count = stamp_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_timing_result want;
        t_timing_result got;
        if (!i_rst_n) begin
            period_q8 = PERIOD_RST;
            leniency_ns = LENIENCY_RST;
            delay_ns = DELAY_RST;
            limit_reg = LIMIT_RST;
            stamp_cnt = '0;
            last_stamp = '0;
            offset_acc = '0;
            origin = '0;
            steps = '0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PERIOD:   period_q8 = i_cfg_data[PER_W-1:0];
                    CFG_LENIENCY: leniency_ns = i_cfg_data[NS_W-1:0];
                    CFG_DELAY:    delay_ns = i_cfg_data[NS_W-1:0];
                    CFG_LIMIT:    limit_reg = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            // result side first: a beat accepted in this cycle cannot be answered yet
            if (m_axis_tvalid && m_axis_tready) begin
                got.next_ns = m_axis_tdata[62:0];
                got.count = m_axis_tdata[71:63];
                got.steady = m_axis_tuser[0];
                got.restarted = m_axis_tuser[1];
                if (results_due.size() == 0) begin
                    $error("unexpected result beat: next_timing_ns %0h", got.next_ns);
                    fail_tally++;
                end else begin
                    want = results_due.pop_front();
                    if (got.next_ns !== want.next_ns) begin
                        $error("next_timing_ns: expected %0h, got %0h",
                               want.next_ns, got.next_ns);
                        fail_tally++;
                    end
                    if (got.steady !== want.steady) begin
                        $error("steady: expected %0d, got %0d", want.steady, got.steady);
                        fail_tally++;
                    end
                    if (got.count !== want.count) begin
                        $error("history_count: expected %0d, got %0d", want.count, got.count);
                        fail_tally++;
                    end
                    if (got.restarted !== want.restarted) begin
                        $error("restarted: expected %0d, got %0d",
                               want.restarted, got.restarted);
                        fail_tally++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(predict_beat(s_axis_tuser, s_axis_tdata[61:0],
                                                   s_axis_tdata[62]));
        end
        o_mismatches <= fail_tally;
        o_pending <= results_due.size();
    end

endmodule

[verif/tb.sv]
// tb: top of the poll timing stabilizer testbench; drives config writes and feed/query
// beats, throttles the result stream and gives the verdict.
// Depends on pts_pkg, poll_timing_stabilizer and pts_timing_checker.
`timescale 1ns / 1ps

module tb import pts_pkg::*; ();

    localparam int          STALL_LIMIT  = 2000;  // cycles with no beat accepted
    localparam int          CHOKE_CYCLES = 150;   // one long back-pressure stretch
    localparam int          DRAIN_CYCLES = 80;    // extra wait after the drain; the mean path is the slowest
    localparam logic [63:0] TS_MASK      = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] P_NS         = 64'(PERIOD_RST) >> FRAC_W;  // 16683350
    localparam logic [63:0] L_NS         = 64'(LENIENCY_RST);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;   // [61:0] timestamp_ns, [62] advance
    logic                  s_axis_tuser = 1'b0; // [0] op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [71:0]           m_axis_tdata;        // [62:0] next_timing_ns, [71:63] history_count
    logic [1:0]            m_axis_tuser;        // [0] steady, [1] restarted

    int mismatches;
    int pending;
    int idle_cycles = 0;

    // what the stimulus knows of the current setup and stamp stream
    logic [PER_W-1:0] per_q8 = PERIOD_RST;
    logic [NS_W-1:0]  len_ns = LENIENCY_RST;
    logic [63:0]      prev_stamp = '0;
    bit               fed_last = 1'b0;
    bit               rush = 1'b0;       // both sides skip idling while set
    bit               choke_req = 1'b0;  // asks the receiver for one long hold-off

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    poll_timing_stabilizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pts_timing_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Watchdog: a hang on either stream ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("poll_timing_stabilizer verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: a random stall before each beat, none while rushing. Once the
    // stimulus asks for it, one long hold-off so the block backs up into its input.
    initial begin
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            int hold;
            hold = rush ? 0 : $urandom_range(11, 0);
            if (choke_req) begin
                hold = CHOKE_CYCLES;
                choke_req = 1'b0;
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge i_clk);
        end
    end

    function automatic logic [63:0] any_stamp();
        return {$urandom, $urandom} & TS_MASK;
    endfunction

    // One input beat. Entered and left at a falling edge; valid stays up when the
    // next beat follows with no gap.
    task automatic send_beat(input logic op, input logic [63:0] ts, input logic adv);
        int gap;
        gap = rush ? 0 : $urandom_range(11, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, adv, ts[TS_W-1:0]};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
        if (op == OP_FEED)
            prev_stamp = ts & TS_MASK;
        fed_last = (op == OP_FEED);
        if ($urandom_range(29, 0) == 0)
            rush = !rush;
    endtask

    // Stop offering and wait for every predicted result to come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PERIOD)
            per_q8 = val[PER_W-1:0];
        else if (idx == CFG_LENIENCY)
            len_ns = val[NS_W-1:0];
    endtask

    // Registers only change with the block drained.
    task automatic program_regs(input logic [63:0] per, input logic [63:0] len,
                                input logic [63:0] dly, input logic [63:0] lim);
        settle();
        cfg_write(CFG_PERIOD, per);
        cfg_write(CFG_LENIENCY, len);
        cfg_write(CFG_DELAY, dly);
        cfg_write(CFG_LIMIT, lim);
    endtask

    // Mostly frame-like traffic: a feed about one period after the last stamp, then
    // often a query that advances the step counter, which keeps steady state on trend.
    // Stray feeds use jitter up to 1.5x leniency, so some leave the band; noise beats
    // carry any op, stamp and advance bit.
    task automatic run_traffic(input int items, input int query_pct,
                               input int stray_pct, input int noise_pct);
        int          roll;
        int unsigned span;
        longint      jit;
        logic [63:0] per_ns;
        for (int i = 0; i < items; i++) begin
            per_ns = 64'(per_q8 >> FRAC_W);
            roll = $urandom_range(99, 0);
            if (roll < noise_pct) begin
                send_beat(1'($urandom_range(1, 0)), any_stamp(), 1'($urandom_range(1, 0)));
            end else if (roll >= noise_pct + stray_pct && fed_last &&
                         $urandom_range(99, 0) < query_pct) begin
                send_beat(OP_QUERY, prev_stamp + 64'($urandom_range(per_ns[31:0], 0)),
                          $urandom_range(15, 0) != 0);
            end else begin
                if (roll < noise_pct + stray_pct)
                    span = 32'(len_ns) + 32'(len_ns) / 32'd2;
                else
                    span = 32'(len_ns) / 32'd4;
                jit = longint'($urandom_range(2 * span, 0)) - longint'(span);
                send_beat(OP_FEED, prev_stamp + per_ns + 64'(jit),
                          1'($urandom_range(1, 0)));
            end
        end
    endtask

    initial begin
        logic [63:0] rnd_per;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset configuration ---
        send_beat(OP_QUERY, 64'd0, 1'b0);               // empty history, result wraps negative
        send_beat(OP_QUERY, TS_MASK, 1'b1);             // empty history, largest stamp
        send_beat(OP_FEED, TS_MASK, 1'b0);              // first stamp at the top
        send_beat(OP_QUERY, TS_MASK, 1'b0);             // mean of a single stamp
        send_beat(OP_FEED, 64'd0, 1'b1);                // huge backward gap -> restart
        send_beat(OP_FEED, P_NS, 1'b0);                 // nominal gap
        send_beat(OP_FEED, 64'd2 * P_NS + L_NS, 1'b0);  // upper edge of the band, kept
        send_beat(OP_FEED, 64'd3 * P_NS + 64'd2 * L_NS + 64'd1, 1'b0);  // one past the upper edge
        send_beat(OP_FEED, 64'd4 * P_NS + L_NS + 64'd1, 1'b0);  // just below the lower edge
        send_beat(OP_FEED, 64'd5 * P_NS + 64'd2, 1'b0);         // just inside the lower edge
        send_beat(OP_QUERY, 64'd5 * P_NS + 64'd100, 1'b1);      // mean of two stamps
        send_beat(OP_FEED, 64'd5 * P_NS + 64'd2 + 64'h1_0000_0001, 1'b0);  // gap beyond 2^32
        send_beat(OP_QUERY, any_stamp(), 1'b1);

        // --- reset config, frame-like with some strays; long stall halfway ---
        run_traffic(90, 100, 10, 5);
        choke_req = 1'b1;
        run_traffic(90, 100, 10, 5);

        // limit one: steady right away, restarts keep it steady on the old origin
        program_regs(64'(PERIOD_RST), 64'd0, 64'd0, 64'd1);
        run_traffic(40, 100, 20, 10);
        // limit zero behaves as one
        program_regs(64'(PERIOD_RST), 64'd500000, 64'd300000, 64'd0);
        run_traffic(40, 100, 20, 10);

        // limit above the ceiling -> 256; clean feeds only so history can fill
        program_regs(64'(PERIOD_RST), 64'd2000000, 64'($urandom_range(1000000000, 0)),
                     64'd511);
        run_traffic(360, 30, 0, 0);

        // limit dropped below the count; widest period, leniency and delay of 1e9 ns
        program_regs(64'h0F_FFFF_FFFF, 64'd1000000000, 64'd1000000000, 64'd2);
        run_traffic(100, 80, 15, 10);

        // smallest period: its whole-ns part is zero, so feeds aim at the ns of the last stamp
        program_regs(64'd1, 64'($urandom_range(1000, 0)), 64'd0, 64'd5);
        run_traffic(80, 80, 15, 10);

        // random setups
        repeat (4) begin
            rnd_per = {28'd0, 4'($urandom_range(15, 0)), 32'($urandom)};
            if (rnd_per == '0)
                rnd_per = 64'd1;
            program_regs(rnd_per, 64'($urandom_range(1000000000, 0)),
                         64'($urandom_range(1000000000, 0)), 64'($urandom_range(20, 1)));
            run_traffic(35, 80, 10, 10);
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("poll_timing_stabilizer verification clean");
        else
            $display("poll_timing_stabilizer verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/pts_pkg.sv
rtl/pts_mul.sv
rtl/pts_div.sv
rtl/poll_timing_stabilizer.sv
verif/pts_timing_checker.sv
verif/tb.sv
